@@ rtl/mk32_pkg.sv @@
package mk32_pkg;
	localparam int unsigned CFG_SIGMA_SQ = 0;
	localparam logic [15:0] SIGMA_RESET = 16'd256;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam int unsigned SERIES_TERMS = 14;
endpackage

@@ rtl/mk32_if.sv @@
interface mk32_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] coord_a;
	logic [15:0] coord_b;
	logic [15:0] inv_len;
	logic        last_dim;
	modport source(output valid, coord_a, coord_b, inv_len, last_dim, input ready);
	modport sink(input valid, coord_a, coord_b, inv_len, last_dim, output ready);
endinterface

interface mk32_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] kernel_value;
	logic        overflow;
	modport source(output valid, kernel_value, overflow, input ready);
	modport sink(input valid, kernel_value, overflow, output ready);
endinterface

@@ rtl/matern32_kernel_eval.sv @@
// Matern 3/2 kernel evaluator. One word per dimension on the input channel; the word with
// last_dim set produces one result word, sigma_sq*(1+t)*exp(-t) in unsigned Q16.16 with
// t = sqrt(3*sum). Everything runs on one 33x33 multiplier and one 33-step shift-subtract
// divider under a sequencer, and the input is not ready while a word is in work.
// A non-last word goes through the accept, multiply, square and accumulate steps.
// A last word goes on with the range check, a 32-step square root and a test of t, two
// 14-term exp series at frac(t) and at 1.0 (each term one multiply, the divide and an
// update), n multiplies by exp(-1) where n is the integer part of t (0 to 31), then g,
// the sigma scaling and the output load. A distance too large for t skips straight to
// the output, as does one whose t reaches 32.0. The result waits in an output register;
// a word only stalls there while that register still holds an unread result.
module matern32_kernel_eval (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	mk32_in_if.sink     in_ch,
	mk32_out_if.source  out_ch
);
	localparam logic [4:0] S_IDLE = 5'd0, S_MUL1 = 5'd1, S_MUL2 = 5'd2, S_ACC = 5'd3,
		S_X = 5'd4, S_SQRT = 5'd5, S_ESET = 5'd6, S_EMUL = 5'd7, S_EDIV = 5'd8,
		S_EEND = 5'd9, S_NMUL = 5'd10, S_GMUL = 5'd11, S_VMUL = 5'd12, S_OUT = 5'd13;

	logic [4:0]  state_q;
	logic [15:0] sigma_q;
	logic [63:0] acc_q;
	logic        sat_q, ovf_q;
	logic [15:0] w_q;
	logic        last_q;
	logic [63:0] r_q;      // general work register
	logic [32:0] op_a, op_b;
	logic [65:0] prod;
	logic [63:0] vprod;    // sigma * g, rounded to Q16.16
	// sqrt
	logic [63:0] sv_q, root_q, bit_q;
	// series
	logic [32:0] term_q;
	logic signed [35:0] sum_q, sum_next;
	logic [3:0]  k_q;
	logic        pass_q;   // 0: series at f, 1: series at 1.0
	logic [15:0] f_q;
	logic [32:0] r_frac_q, e1_q;
	logic [4:0]  n_q;
	logic [20:0] tt_q;     // t in Q16.16, below 32.0
	// divider: 33-bit term by k, remainder stays below k
	logic [32:0] dnum_q, dquo_q;
	logic [3:0]  drem_q;
	logic [5:0]  dcnt_q;
	logic [5:0]  drem_next;
	logic [31:0] kv_q;
	logic        ov_out_q, ovalid_q, out_load;
	logic        cfg_hit;

	function automatic logic [32:0] clamp(input logic signed [35:0] v);
		if (v < 0) return 33'd0;
		else if (v > $signed(36'(mk32_pkg::ONE_Q32))) return mk32_pkg::ONE_Q32;
		else return v[32:0];
	endfunction

	assign cfg_hit = (paddr[2] == 1'(mk32_pkg::CFG_SIGMA_SQ));
	assign pready = 1'b1;
	assign prdata = cfg_hit ? {16'd0, sigma_q} : 32'd0;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.kernel_value = kv_q;
	assign out_ch.overflow = ov_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sigma_q <= mk32_pkg::SIGMA_RESET;
		else if (psel && penable && pwrite && cfg_hit)
			sigma_q <= pwdata[15:0];
	end

	// shared multiplier
	always_comb begin
		op_a = 33'd0; op_b = 33'd0;
		case (state_q)
			S_MUL1: begin op_a = r_q[32:0]; op_b = {17'd0, w_q}; end
			S_MUL2: begin op_a = r_q[32:0]; op_b = r_q[32:0]; end
			S_EMUL: begin op_a = term_q; op_b = pass_q ? 33'h1_0000 : {17'd0, f_q}; end
			S_NMUL: begin op_a = r_frac_q; op_b = e1_q; end
			S_GMUL: begin op_a = {11'd0, ({1'b0, tt_q} + 22'h01_0000)}; op_b = r_frac_q; end
			S_VMUL: begin op_a = r_q[32:0]; op_b = {17'd0, sigma_q}; end
			default: ;
		endcase
		prod = {33'd0, op_a} * {33'd0, op_b};
	end

	assign vprod = (prod[63:0] + 64'd128) >> 8;
	assign drem_next = {1'b0, drem_q, dnum_q[32]} - {2'd0, k_q};
	assign sum_next = k_q[0] ? sum_q - $signed({3'd0, dquo_q}) : sum_q + $signed({3'd0, dquo_q});
	assign out_load = (state_q == S_OUT) && (!ovalid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (out_load) ovalid_q <= 1'b1;
		else if (out_ch.ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; acc_q <= '0; sat_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					r_q <= {48'd0, ($signed(in_ch.coord_a) >= $signed(in_ch.coord_b)) ?
						16'(in_ch.coord_a - in_ch.coord_b) : 16'(in_ch.coord_b - in_ch.coord_a)};
					w_q <= in_ch.inv_len; last_q <= in_ch.last_dim; state_q <= S_MUL1;
				end
				S_MUL1: begin r_q <= (prod[63:0] + 64'd128) >> 8; state_q <= S_MUL2; end
				S_MUL2: begin r_q <= prod[63:0]; state_q <= S_ACC; end
				S_ACC: begin
					if (acc_q > ~r_q) begin acc_q <= '1; sat_q <= 1'b1; end
					else acc_q <= acc_q + r_q;
					state_q <= last_q ? S_X : S_IDLE;
				end
				S_X: begin
					ovf_q <= sat_q;
					if (acc_q > 64'h5555_5555_5555_5555 || (acc_q * 3) >= 64'h1_0000_0000_0000) begin
						r_frac_q <= '0; state_q <= S_OUT; r_q <= '0;
					end else begin
						sv_q <= (acc_q * 3) << 16; root_q <= '0; bit_q <= 64'h4000_0000_0000_0000;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q == 0) begin
						if (root_q >= 64'h20_0000) begin r_frac_q <= '0; state_q <= S_OUT; r_q <= '0; end
						else begin
							tt_q <= root_q[20:0]; n_q <= root_q[20:16]; f_q <= root_q[15:0];
							pass_q <= 1'b0; state_q <= S_ESET;
						end
					end else begin
						if (sv_q >= root_q + bit_q) begin
							sv_q <= sv_q - (root_q + bit_q); root_q <= (root_q >> 1) + bit_q;
						end else root_q <= root_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				S_ESET: begin term_q <= mk32_pkg::ONE_Q32; sum_q <= 36'(mk32_pkg::ONE_Q32); k_q <= 4'd1;
					state_q <= S_EMUL; end
				S_EMUL: begin dnum_q <= prod[48:16]; drem_q <= '0; dcnt_q <= '0; state_q <= S_EDIV; end
				S_EDIV: begin
					if (!drem_next[5]) drem_q <= drem_next[3:0];
					else drem_q <= {drem_q[2:0], dnum_q[32]};
					dquo_q <= {dquo_q[31:0], ~drem_next[5]};
					dnum_q <= {dnum_q[31:0], 1'b0};
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd32) state_q <= S_EEND;
				end
				S_EEND: begin
					term_q <= dquo_q;
					sum_q <= sum_next;
					if (k_q == 4'(mk32_pkg::SERIES_TERMS)) begin
						if (!pass_q) begin
							r_frac_q <= clamp(sum_next); pass_q <= 1'b1; state_q <= S_ESET;
						end else begin
							e1_q <= clamp(sum_next); state_q <= S_NMUL;
						end
					end else begin k_q <= k_q + 4'd1; state_q <= S_EMUL; end
				end
				S_NMUL: begin
					if (n_q == 5'd0) state_q <= S_GMUL;
					else begin r_frac_q <= 33'((prod + 66'h8000_0000) >> 32); n_q <= n_q - 5'd1; end
				end
				S_GMUL: begin
					r_q <= (r_frac_q == 0) ? 64'd0 : 64'((prod + 66'h8000_0000) >> 32);
					state_q <= (r_frac_q == 0) ? S_OUT : S_VMUL;
				end
				S_VMUL: begin
					if (vprod > 64'hFFFF_FFFF) begin
						r_q <= 64'hFFFF_FFFF; ovf_q <= 1'b1;
					end else r_q <= vprod;
					state_q <= S_OUT;
				end
				S_OUT: if (out_load) begin
					kv_q <= r_q[31:0]; ov_out_q <= ovf_q;
					acc_q <= '0; sat_q <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kernel_value)
		&& $stable(out_ch.overflow))
		else $error("result dropped");
endmodule
